// ===== src/viewport_tile_generator_defines.svh =====
`ifndef VIEWPORT_TILE_GENERATOR_DEFINES_SVH
`define VIEWPORT_TILE_GENERATOR_DEFINES_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define VTG_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("viewport tile generator check failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define VTG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("viewport tile generator check failed");

`endif

// ===== src/vtg_pkg.sv =====
`timescale 1ns / 1ps

package vtg_pkg;

   localparam int unsigned COORD_W    = 13;
   localparam int unsigned SEG_W      = 11;
   localparam int unsigned IMG_W      = 13;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned LEFT_W     = 14;
   localparam int unsigned EDGE_W     = 15;
   localparam int unsigned HALF_W     = 16;
   localparam int unsigned PAIR_W     = 2 * HALF_W;
   localparam int unsigned RUN_W      = 2;
   localparam int unsigned CNT_W      = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;

   localparam int unsigned MAX_TILES_DEFAULT = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd2;

   localparam logic [SEG_W-1:0] SEGMENT_RESET      = 11'd128;
   localparam logic [IMG_W-1:0] IMAGE_HEIGHT_RESET = 13'd480;

   typedef struct packed {
      logic load;
      logic count_step;
      logic walk_init;
      logic emit;
      logic emit_single;
   } vtg_cmd_type;

   typedef struct packed {
      logic bad;
      logic zero;
      logic count_done;
      logic last_tile;
      logic out_free;
   } vtg_sts_type;

endpackage

// ===== src/vtg_req_if.sv =====
`timescale 1ns / 1ps

interface vtg_req_if import vtg_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] origin_x;
   logic signed [COORD_W-1:0] origin_y;
   logic signed [COORD_W-1:0] view_width;
   logic signed [COORD_W-1:0] view_height;

   modport source (output valid, origin_x, origin_y, view_width, view_height, input ready);
   modport sink (input valid, origin_x, origin_y, view_width, view_height, output ready);
endinterface

// ===== src/vtg_rsp_if.sv =====
`timescale 1ns / 1ps

interface vtg_rsp_if import vtg_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic                     bad_size;
   logic                     tile_valid;
   logic [IDX_W-1:0]         tile_index;
   logic signed [LEFT_W-1:0] tile_left;
   logic signed [EDGE_W-1:0] tile_bottom;
   logic [SEG_W-1:0]         tile_width;
   logic [SEG_W-1:0]         tile_height;
   logic signed [EDGE_W-1:0] tile_right;
   logic signed [EDGE_W-1:0] tile_top;
   logic [SEG_W-1:0]         scale_x;
   logic [PAIR_W-1:0]        offset_pair;
   logic [RUN_W-1:0]         run_end;

   modport source (output valid, bad_size, tile_valid, tile_index, tile_left, tile_bottom,
                   tile_width, tile_height, tile_right, tile_top, scale_x, offset_pair,
                   run_end, input ready);
   modport sink (input valid, bad_size, tile_valid, tile_index, tile_left, tile_bottom,
                 tile_width, tile_height, tile_right, tile_top, scale_x, offset_pair,
                 run_end, output ready);
endinterface

// ===== src/vtg_csr_if.sv =====
`timescale 1ns / 1ps

interface vtg_csr_if import vtg_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/vtg_datapath.sv =====
`timescale 1ns / 1ps

module vtg_datapath import vtg_pkg::*; #(
   parameter int unsigned MAX_TILES = MAX_TILES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  vtg_cmd_type               cmd,
   output vtg_sts_type               sts,
   input  logic signed [COORD_W-1:0] origin_x,
   input  logic signed [COORD_W-1:0] origin_y,
   input  logic signed [COORD_W-1:0] view_width,
   input  logic signed [COORD_W-1:0] view_height,
   input  logic [SEG_W-1:0]          segment_width,
   input  logic [SEG_W-1:0]          segment_height,
   input  logic [IMG_W-1:0]          image_height,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_bad_size,
   output logic                      rsp_tile_valid,
   output logic [IDX_W-1:0]          rsp_tile_index,
   output logic signed [LEFT_W-1:0]  rsp_tile_left,
   output logic signed [EDGE_W-1:0]  rsp_tile_bottom,
   output logic [SEG_W-1:0]          rsp_tile_width,
   output logic [SEG_W-1:0]          rsp_tile_height,
   output logic signed [EDGE_W-1:0]  rsp_tile_right,
   output logic signed [EDGE_W-1:0]  rsp_tile_top,
   output logic [SEG_W-1:0]          rsp_scale_x,
   output logic [PAIR_W-1:0]         rsp_offset_pair,
   output logic [RUN_W-1:0]          rsp_run_end
);

   localparam logic [CNT_W-1:0]   CAP   = CNT_W'(MAX_TILES + 1);
   localparam logic [CNT_W-1:0]   LIMIT = CNT_W'(MAX_TILES);
   localparam logic [2*CNT_W-1:0] LIMIT_WIDE = (2*CNT_W)'(MAX_TILES);

   logic signed [COORD_W-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic [SEG_W-1:0]          sw_ff, sw_in, sh_ff, sh_in;
   logic [IMG_W-1:0]          ih_ff, ih_in;
   logic [COORD_W:0]          cacc_ff, cacc_in, racc_ff, racc_in;
   logic [CNT_W-1:0]          cols_ff, cols_in, rows_ff, rows_in;
   logic [CNT_W-1:0]          total_ff, total_in, n_ff, n_in;
   logic                      ovf_ff, ovf_in;
   logic signed [EDGE_W-1:0]  x0_ff, x0_in, y0_ff, y0_in;
   logic signed [COORD_W:0]   remw_ff, remw_in, remh_ff, remh_in;

   logic                      out_valid_ff, out_valid_in;
   logic                      bad_ff, bad_in, tv_ff, tv_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic signed [LEFT_W-1:0]  left_ff, left_in;
   logic signed [EDGE_W-1:0]  bottom_ff, bottom_in, right_ff, right_in, top_ff, top_in;
   logic [SEG_W-1:0]          width_ff, width_in, height_ff, height_in, scale_ff, scale_in;
   logic [PAIR_W-1:0]         pair_ff, pair_in;
   logic [RUN_W-1:0]          run_ff, run_in;

   logic [COORD_W:0]          w_u, h_u;
   logic                      col_done, row_done, bad_s, zero_s, last_s, row_end;
   logic [2*CNT_W-1:0]        prod;
   logic                      prod_ovf;
   logic signed [EDGE_W-1:0]  sw_e, sh_e, remw_e, remh_e, lw_e, lh_e, ih_e;
   logic signed [EDGE_W-1:0]  top_e, bottom_e, right_e;
   logic [HALF_W-1:0]         offx, offy;
   logic [SEG_W-1:0]          scale_s;

   always_comb begin
      w_u      = {1'b0, w_ff};
      h_u      = {1'b0, h_ff};
      col_done = (cols_ff == CAP) || (cacc_ff >= w_u);
      row_done = (rows_ff == CAP) || (racc_ff >= h_u);
      bad_s    = w_ff[COORD_W-1] || h_ff[COORD_W-1];
      zero_s   = (w_ff == '0) || (h_ff == '0);
      prod     = (2*CNT_W)'(cols_ff) * (2*CNT_W)'(rows_ff);
      prod_ovf = prod > LIMIT_WIDE;

      sw_e     = $signed({{(EDGE_W-SEG_W){1'b0}}, sw_ff});
      sh_e     = $signed({{(EDGE_W-SEG_W){1'b0}}, sh_ff});
      ih_e     = $signed({{(EDGE_W-IMG_W){1'b0}}, ih_ff});
      remw_e   = EDGE_W'(remw_ff);
      remh_e   = EDGE_W'(remh_ff);
      lw_e     = (remw_e < sw_e) ? remw_e : sw_e;
      lh_e     = (remh_e < sh_e) ? remh_e : sh_e;
      top_e    = ih_e - y0_ff;
      bottom_e = top_e - lh_e;
      right_e  = x0_ff + lw_e;
      row_end  = remw_e <= sw_e;
      last_s   = n_ff == (total_ff - 1'b1);

      scale_s  = w_ff[COORD_W-2:1];
      offx     = HALF_W'(x_ff) + {{(HALF_W-COORD_W+1){1'b0}}, w_ff[COORD_W-1:1]};
      offy     = HALF_W'(y_ff) - {{(HALF_W-COORD_W+1){1'b0}}, h_ff[COORD_W-1:1]}
                 + {{(HALF_W-IMG_W){1'b0}}, ih_ff};
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      sw_in    = sw_ff;
      sh_in    = sh_ff;
      ih_in    = ih_ff;
      cacc_in  = cacc_ff;
      racc_in  = racc_ff;
      cols_in  = cols_ff;
      rows_in  = rows_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      n_in     = n_ff;
      x0_in    = x0_ff;
      y0_in    = y0_ff;
      remw_in  = remw_ff;
      remh_in  = remh_ff;

      if (cmd.load) begin
         x_in    = origin_x;
         y_in    = origin_y;
         w_in    = view_width;
         h_in    = view_height;
         sw_in   = (segment_width == '0) ? SEG_W'(1) : segment_width;
         sh_in   = (segment_height == '0) ? SEG_W'(1) : segment_height;
         ih_in   = image_height;
         cacc_in = '0;
         racc_in = '0;
         cols_in = '0;
         rows_in = '0;
      end

      if (cmd.count_step) begin
         if (!col_done) begin
            cacc_in = cacc_ff + {{(COORD_W+1-SEG_W){1'b0}}, sw_ff};
            cols_in = cols_ff + 1'b1;
         end
         if (!row_done) begin
            racc_in = racc_ff + {{(COORD_W+1-SEG_W){1'b0}}, sh_ff};
            rows_in = rows_ff + 1'b1;
         end
      end

      if (cmd.walk_init) begin
         total_in = prod_ovf ? LIMIT : prod[CNT_W-1:0];
         ovf_in   = prod_ovf;
         n_in     = '0;
         x0_in    = EDGE_W'(x_ff);
         y0_in    = EDGE_W'(y_ff);
         remw_in  = (COORD_W+1)'(w_ff);
         remh_in  = (COORD_W+1)'(h_ff);
      end

      if (cmd.emit) begin
         n_in = n_ff + 1'b1;
         if (row_end) begin
            x0_in   = EDGE_W'(x_ff);
            remw_in = (COORD_W+1)'(w_ff);
            y0_in   = y0_ff + sh_e;
            remh_in = remh_ff - (COORD_W+1)'(sh_e);
         end else begin
            x0_in   = x0_ff + sw_e;
            remw_in = remw_ff - (COORD_W+1)'(sw_e);
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      bad_in       = bad_ff;
      tv_in        = tv_ff;
      idx_in       = idx_ff;
      left_in      = left_ff;
      bottom_in    = bottom_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      right_in     = right_ff;
      top_in       = top_ff;
      scale_in     = scale_ff;
      pair_in      = pair_ff;
      run_in       = run_ff;

      if (cmd.emit) begin
         out_valid_in = 1'b1;
         bad_in       = 1'b0;
         tv_in        = 1'b1;
         idx_in       = n_ff[IDX_W-1:0];
         left_in      = x0_ff[LEFT_W-1:0];
         bottom_in    = bottom_e;
         width_in     = lw_e[SEG_W-1:0];
         height_in    = lh_e[SEG_W-1:0];
         right_in     = right_e;
         top_in       = top_e;
         scale_in     = scale_s;
         pair_in      = {offx, offy};
         run_in       = {ovf_ff, last_s};
      end else if (cmd.emit_single) begin
         out_valid_in = 1'b1;
         bad_in       = bad_s;
         tv_in        = 1'b0;
         idx_in       = '0;
         left_in      = '0;
         bottom_in    = '0;
         width_in     = '0;
         height_in    = '0;
         right_in     = '0;
         top_in       = '0;
         scale_in     = bad_s ? '0 : scale_s;
         pair_in      = bad_s ? '0 : {offx, offy};
         run_in       = {1'b0, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      w_ff      <= w_in;
      h_ff      <= h_in;
      sw_ff     <= sw_in;
      sh_ff     <= sh_in;
      ih_ff     <= ih_in;
      cacc_ff   <= cacc_in;
      racc_ff   <= racc_in;
      cols_ff   <= cols_in;
      rows_ff   <= rows_in;
      total_ff  <= total_in;
      ovf_ff    <= ovf_in;
      n_ff      <= n_in;
      x0_ff     <= x0_in;
      y0_ff     <= y0_in;
      remw_ff   <= remw_in;
      remh_ff   <= remh_in;
      bad_ff    <= bad_in;
      tv_ff     <= tv_in;
      idx_ff    <= idx_in;
      left_ff   <= left_in;
      bottom_ff <= bottom_in;
      width_ff  <= width_in;
      height_ff <= height_in;
      right_ff  <= right_in;
      top_ff    <= top_in;
      scale_ff  <= scale_in;
      pair_ff   <= pair_in;
      run_ff    <= run_in;
   end

   assign sts.bad        = bad_s;
   assign sts.zero       = zero_s;
   assign sts.count_done = col_done && row_done;
   assign sts.last_tile  = last_s;
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid       = out_valid_ff;
   assign rsp_bad_size    = bad_ff;
   assign rsp_tile_valid  = tv_ff;
   assign rsp_tile_index  = idx_ff;
   assign rsp_tile_left   = left_ff;
   assign rsp_tile_bottom = bottom_ff;
   assign rsp_tile_width  = width_ff;
   assign rsp_tile_height = height_ff;
   assign rsp_tile_right  = right_ff;
   assign rsp_tile_top    = top_ff;
   assign rsp_scale_x     = scale_ff;
   assign rsp_offset_pair = pair_ff;
   assign rsp_run_end     = run_ff;

endmodule

// ===== src/vtg_ctrl.sv =====
`timescale 1ns / 1ps
`include "viewport_tile_generator_defines.svh"

module vtg_ctrl import vtg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vtg_sts_type sts,
   output vtg_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_COUNT  = 3'd2;
   localparam logic [2:0] ST_EMIT   = 3'd3;
   localparam logic [2:0] ST_SINGLE = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (sts.bad || sts.zero) ? ST_SINGLE : ST_COUNT;
         end
         ST_COUNT: begin
            if (sts.count_done) begin
               cmd.walk_init = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               cmd.count_step = 1'b1;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.last_tile) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SINGLE: begin
            if (sts.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `VTG_ASSERT_SAME(a_cmd_onehot, clock, reset, 1'b1, $onehot0(cmd))
   `VTG_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit || cmd.emit_single, sts.out_free)
   `VTG_ASSERT_NEXT(a_load_check, clock, reset, cmd.load, state_ff == ST_CHECK)
   `VTG_ASSERT_SAME(a_walk_clean, clock, reset, cmd.walk_init, !sts.bad && !sts.zero)

endmodule

// ===== src/viewport_tile_generator.sv =====
`timescale 1ns / 1ps
// After acceptance a request is loaded and checked; for a tile request the column and row
// counts are then found by repeated addition, capped at MAX_TILES + 1, before tiles go out.
// Tiles then go out at one per cycle while the response channel takes them, and wait when not.
// An error or zero-area request gives a single response. One request is in work at a time.
// Reset is synchronous and active high; it clears the control state and loads the
// registers with segment size 128 by 128 and image height 480.

module viewport_tile_generator import vtg_pkg::*; #(
   parameter int unsigned MAX_TILES = MAX_TILES_DEFAULT
) (
   input logic            clock,
   input logic            reset,
   vtg_req_if.sink        req_chan,
   vtg_rsp_if.source      rsp_chan,
   vtg_csr_if.sink        csr_chan
);

   logic [SEG_W-1:0] seg_w_ff, seg_w_in, seg_h_ff, seg_h_in;
   logic [IMG_W-1:0] img_h_ff, img_h_in;
   vtg_cmd_type      cmd;
   vtg_sts_type      sts;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      seg_w_in = seg_w_ff;
      seg_h_in = seg_h_ff;
      img_h_in = img_h_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SEGMENT_WIDTH:  seg_w_in = csr_chan.data[SEG_W-1:0];
            CSR_SEGMENT_HEIGHT: seg_h_in = csr_chan.data[SEG_W-1:0];
            CSR_IMAGE_HEIGHT:   img_h_in = csr_chan.data[IMG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_w_ff <= SEGMENT_RESET;
         seg_h_ff <= SEGMENT_RESET;
         img_h_ff <= IMAGE_HEIGHT_RESET;
      end else begin
         seg_w_ff <= seg_w_in;
         seg_h_ff <= seg_h_in;
         img_h_ff <= img_h_in;
      end
   end

   vtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vtg_datapath #(
      .MAX_TILES (MAX_TILES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .origin_x        (req_chan.origin_x),
      .origin_y        (req_chan.origin_y),
      .view_width      (req_chan.view_width),
      .view_height     (req_chan.view_height),
      .segment_width   (seg_w_ff),
      .segment_height  (seg_h_ff),
      .image_height    (img_h_ff),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_bad_size    (rsp_chan.bad_size),
      .rsp_tile_valid  (rsp_chan.tile_valid),
      .rsp_tile_index  (rsp_chan.tile_index),
      .rsp_tile_left   (rsp_chan.tile_left),
      .rsp_tile_bottom (rsp_chan.tile_bottom),
      .rsp_tile_width  (rsp_chan.tile_width),
      .rsp_tile_height (rsp_chan.tile_height),
      .rsp_tile_right  (rsp_chan.tile_right),
      .rsp_tile_top    (rsp_chan.tile_top),
      .rsp_scale_x     (rsp_chan.scale_x),
      .rsp_offset_pair (rsp_chan.offset_pair),
      .rsp_run_end     (rsp_chan.run_end)
   );

endmodule
